// ===== hw/rtl/grid_cell_boundary_edges_unit_assert.svh =====
// ----------------------------------------------------------------------------
// grid cell boundary edges: assertion macros
// shared assertion forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef GRID_CELL_BOUNDARY_EDGES_UNIT_ASSERT_SVH
`define GRID_CELL_BOUNDARY_EDGES_UNIT_ASSERT_SVH

// same-cycle implication
`define GCBE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define GCBE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gcbe_pkg.sv =====
// ----------------------------------------------------------------------------
// gcbe_pkg
// shared types and constants of the grid cell boundary edge unit
// ----------------------------------------------------------------------------
`default_nettype none

package gcbe_pkg;

    localparam int MAX_CELLS_DEF = 64;
    localparam int COORD_W       = 8;
    localparam int CELL_W        = 2 * COORD_W;
    localparam int SEG_W         = 10;
    localparam int FUNC_W        = 2;
    localparam int SIDE_W        = 2;
    localparam int QIDX_W        = 6;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_LOAD  = 2'd1,
        FUNC_QUERY = 2'd2
    } func_t;

    localparam logic [SIDE_W-1:0] SIDE_PX = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_MX = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_PY = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_MY = 2'd3;

    // neighbor hits of one compare
    typedef struct packed {
        logic my;
        logic py;
        logic mx;
        logic px;
    } hits_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gcbe_ram.sv =====
// ----------------------------------------------------------------------------
// gcbe_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module gcbe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hw/rtl/gcbe_nbr.sv =====
// ----------------------------------------------------------------------------
// gcbe_nbr
// neighbor compare: tests one stored cell against the queried cell
// ----------------------------------------------------------------------------
`default_nettype none

module gcbe_nbr
    import gcbe_pkg::*;
(
    input  wire logic signed [COORD_W-1:0] ref_x,
    input  wire logic signed [COORD_W-1:0] ref_y,
    input  wire logic signed [COORD_W-1:0] cand_x,
    input  wire logic signed [COORD_W-1:0] cand_y,
    output hits_t                          hits
);

    // one extra bit keeps x+1 and x-1 exact at the range ends
    logic signed [COORD_W:0] rx;
    logic signed [COORD_W:0] ry;
    logic signed [COORD_W:0] cx;
    logic signed [COORD_W:0] cy;
    logic                    same_x;
    logic                    same_y;

    always_comb
    begin
        rx     = {ref_x[COORD_W-1], ref_x};
        ry     = {ref_y[COORD_W-1], ref_y};
        cx     = {cand_x[COORD_W-1], cand_x};
        cy     = {cand_y[COORD_W-1], cand_y};
        same_x = (cx == rx);
        same_y = (cy == ry);
        hits.px = same_y && (cx == rx + (COORD_W+1)'(1));
        hits.mx = same_y && (cx == rx - (COORD_W+1)'(1));
        hits.py = same_x && (cy == ry + (COORD_W+1)'(1));
        hits.my = same_x && (cy == ry - (COORD_W+1)'(1));
    end

endmodule

`default_nettype wire

// ===== hw/rtl/grid_cell_boundary_edges_unit.sv =====
// ----------------------------------------------------------------------------
// grid_cell_boundary_edges_unit
// keeps a set of occupied grid cells and emits the exposed wall segments
// of one stored cell, one segment per item on the segment channel
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_stall | func, cell_x, cell_y, query_index
//   seg     | out | seg_valid / seg_stall | face_side, start/end x/y, last_edge
//
// clear, load and an out-of-range query finish in ST_IDLE without a stall;
// an in-range query takes the queried cell in ST_REF, makes one ram read
// per stored cell in ST_SCAN, then in ST_EMIT loads one segment per exposed
// side while the output register is free, or returns to idle with none
// req_stall is high from an in-range query's accept until it is back in idle
// reset clears the cell count and the output valid; ram content is undefined
// ----------------------------------------------------------------------------
`default_nettype none

module grid_cell_boundary_edges_unit
    import gcbe_pkg::*;
#(
    parameter int MAX_CELLS = MAX_CELLS_DEF
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    output logic                           req_stall,
    input  wire logic [FUNC_W-1:0]         func,
    input  wire logic signed [COORD_W-1:0] cell_x,
    input  wire logic signed [COORD_W-1:0] cell_y,
    input  wire logic [QIDX_W-1:0]         query_index,
    output logic                           seg_valid,
    input  wire logic                      seg_stall,
    output logic [SIDE_W-1:0]              face_side,
    output logic signed [SEG_W-1:0]        start_x,
    output logic signed [SEG_W-1:0]        start_y,
    output logic signed [SEG_W-1:0]        end_x,
    output logic signed [SEG_W-1:0]        end_y,
    output logic                           last_edge
);

    localparam int AW = $clog2(MAX_CELLS);
    localparam int CW = $clog2(MAX_CELLS + 1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_REF  = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_EMIT = 4'b1000
    } state_t;

    state_t                      state_reg, state_next;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic [CW-1:0]               j_reg, j_next;
    logic [3:0]                  exp_reg, exp_next;
    logic signed [COORD_W-1:0]   ref_x_reg, ref_x_next;
    logic signed [COORD_W-1:0]   ref_y_reg, ref_y_next;

    logic                        seg_valid_reg, seg_valid_next;
    logic [SIDE_W-1:0]           side_reg, side_next;
    logic signed [SEG_W-1:0]     sx_reg, sx_next;
    logic signed [SEG_W-1:0]     sy_reg, sy_next;
    logic signed [SEG_W-1:0]     ex_reg, ex_next;
    logic signed [SEG_W-1:0]     ey_reg, ey_next;
    logic                        last_reg, last_next;

    logic                        accept;
    logic                        seg_free;
    logic                        wr_en;
    logic [AW-1:0]               rd_addr;
    logic [CELL_W-1:0]           rd_data;
    hits_t                       hits;
    logic [3:0]                  pick;
    logic signed [SEG_W-1:0]     x2p, x2m, y2p, y2m;

    gcbe_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MAX_CELLS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (cnt_reg[AW-1:0]),
        .wr_data ({cell_y, cell_x}),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    gcbe_nbr u_nbr (
        .ref_x  (ref_x_reg),
        .ref_y  (ref_y_reg),
        .cand_x (rd_data[COORD_W-1:0]),
        .cand_y (rd_data[CELL_W-1:COORD_W]),
        .hits   (hits)
    );

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign seg_free  = !seg_valid_reg || !seg_stall;
    assign wr_en     = accept && (func == FUNC_LOAD) && (32'(cnt_reg) < MAX_CELLS);
    assign rd_addr   = (state_reg == ST_IDLE) ? AW'(query_index) : j_reg[AW-1:0];

    // doubled-unit edge coordinates of the queried cell
    always_comb
    begin
        x2p = {{(SEG_W-COORD_W-1){ref_x_reg[COORD_W-1]}}, ref_x_reg, 1'b0} + SEG_W'(1);
        x2m = {{(SEG_W-COORD_W-1){ref_x_reg[COORD_W-1]}}, ref_x_reg, 1'b0} - SEG_W'(1);
        y2p = {{(SEG_W-COORD_W-1){ref_y_reg[COORD_W-1]}}, ref_y_reg, 1'b0} + SEG_W'(1);
        y2m = {{(SEG_W-COORD_W-1){ref_y_reg[COORD_W-1]}}, ref_y_reg, 1'b0} - SEG_W'(1);
    end

    // lowest exposed side goes first
    always_comb
    begin
        if (exp_reg[0])
        begin
            pick = 4'b0001;
        end
        else if (exp_reg[1])
        begin
            pick = 4'b0010;
        end
        else if (exp_reg[2])
        begin
            pick = 4'b0100;
        end
        else
        begin
            pick = 4'b1000;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        j_next         = j_reg;
        exp_next       = exp_reg;
        ref_x_next     = ref_x_reg;
        ref_y_next     = ref_y_reg;
        seg_valid_next = seg_valid_reg && seg_stall;
        side_next      = side_reg;
        sx_next        = sx_reg;
        sy_next        = sy_reg;
        ex_next        = ex_reg;
        ey_next        = ey_reg;
        last_next      = last_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (func)
                        FUNC_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        FUNC_LOAD:
                        begin
                            if (wr_en)
                            begin
                                cnt_next = cnt_reg + CW'(1);
                            end
                        end
                        FUNC_QUERY:
                        begin
                            if (32'(query_index) < 32'(cnt_reg))
                            begin
                                j_next     = '0;
                                state_next = ST_REF;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_REF:
            begin
                ref_x_next = rd_data[COORD_W-1:0];
                ref_y_next = rd_data[CELL_W-1:COORD_W];
                exp_next   = 4'b1111;
                j_next     = CW'(1);
                state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                exp_next = exp_reg & ~hits;
                if (j_reg == cnt_reg)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_EMIT:
            begin
                if (exp_reg == 4'b0000)
                begin
                    state_next = ST_IDLE;
                end
                else if (seg_free)
                begin
                    seg_valid_next = 1'b1;
                    exp_next       = exp_reg & ~pick;
                    last_next      = ((exp_reg & ~pick) == 4'b0000);
                    if (pick[0])
                    begin
                        side_next = SIDE_PX;
                        sx_next   = x2p;
                        sy_next   = y2m;
                        ex_next   = x2p;
                        ey_next   = y2p;
                    end
                    else if (pick[1])
                    begin
                        side_next = SIDE_MX;
                        sx_next   = x2m;
                        sy_next   = y2p;
                        ex_next   = x2m;
                        ey_next   = y2m;
                    end
                    else if (pick[2])
                    begin
                        side_next = SIDE_PY;
                        sx_next   = x2p;
                        sy_next   = y2p;
                        ex_next   = x2m;
                        ey_next   = y2p;
                    end
                    else
                    begin
                        side_next = SIDE_MY;
                        sx_next   = x2m;
                        sy_next   = y2m;
                        ex_next   = x2p;
                        ey_next   = y2m;
                    end
                    if ((exp_reg & ~pick) == 4'b0000)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            seg_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            seg_valid_reg <= seg_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        exp_reg   <= exp_next;
        ref_x_reg <= ref_x_next;
        ref_y_reg <= ref_y_next;
        side_reg  <= side_next;
        sx_reg    <= sx_next;
        sy_reg    <= sy_next;
        ex_reg    <= ex_next;
        ey_reg    <= ey_next;
        last_reg  <= last_next;
    end

    assign seg_valid = seg_valid_reg;
    assign face_side = side_reg;
    assign start_x   = sx_reg;
    assign start_y   = sy_reg;
    assign end_x     = ex_reg;
    assign end_y     = ey_reg;
    assign last_edge = last_reg;

`include "grid_cell_boundary_edges_unit_assert.svh"

    `GCBE_ASSERT_IMPL(a_cnt_bound, 1'b1, 32'(cnt_reg) <= MAX_CELLS,
        "cell count above store depth")
    `GCBE_ASSERT_IMPL(a_scan_index, state_reg == ST_SCAN,
        (j_reg != '0) && (j_reg <= cnt_reg), "scan index outside stored cells")
    `GCBE_ASSERT_IMPL(a_seg_src, $rose(seg_valid_reg), $past(state_reg == ST_EMIT),
        "segment loaded outside emit")
    `GCBE_ASSERT_NEXT(a_cnt_hold, state_reg != ST_IDLE, cnt_reg == $past(cnt_reg),
        "cell count changed during a query")

endmodule

`default_nettype wire

// ===== tb/tb_grid_cell_boundary_edges_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_cell_boundary_edges_unit
// self-checking bench for the grid cell boundary edge unit: loads cell sets,
// queries stored cells and checks every emitted wall segment against a
// behavioral copy of the cell store, with random gaps and stalls on both
// channels, one long output hold-off and a full-store phase
// ----------------------------------------------------------------------------

module tb_grid_cell_boundary_edges_unit;

    import gcbe_pkg::*;

    localparam int                CLK_HALF     = 4;
    localparam int                LIMIT_CYCLES = 1000000;
    localparam int                RANDOM_ITEMS = 450;
    localparam int                LONG_HOLD    = 300;
    localparam int                DRAIN_CYCLES = 200;
    localparam logic [FUNC_W-1:0] FUNC_UNUSED  = 2'd3;

    typedef struct {
        logic [SIDE_W-1:0]       side;
        logic signed [SEG_W-1:0] sx;
        logic signed [SEG_W-1:0] sy;
        logic signed [SEG_W-1:0] ex;
        logic signed [SEG_W-1:0] ey;
        logic                    last;
    } wall_t;

    class wall_board;
        logic signed [COORD_W-1:0] cell_xs [MAX_CELLS_DEF];
        logic signed [COORD_W-1:0] cell_ys [MAX_CELLS_DEF];
        int unsigned               cell_count;
        wall_t                     walls_due [$];
        int unsigned               mismatches;

        function new();
            cell_count = 0;
            mismatches = 0;
        endfunction

        function void note_mismatch(string msg);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s", $realtime, msg);
        endfunction

        function void push_wall(logic [SIDE_W-1:0] side, int sx, int sy, int ex, int ey,
                                logic last);
            wall_t w;
            w.side = side;
            w.sx   = SEG_W'(sx);
            w.sy   = SEG_W'(sy);
            w.ex   = SEG_W'(ex);
            w.ey   = SEG_W'(ey);
            w.last = last;
            walls_due.insert(walls_due.size(), w);
        endfunction

        function void note_request(logic [FUNC_W-1:0] f, logic signed [COORD_W-1:0] x,
                                   logic signed [COORD_W-1:0] y, logic [QIDX_W-1:0] q);
            int       px;
            int       py;
            int       nx;
            int       ny;
            bit [3:0] open;
            case (f)
                FUNC_CLEAR:
                    cell_count = 0;
                FUNC_LOAD:
                    if (cell_count < MAX_CELLS_DEF)
                    begin
                        cell_xs[cell_count] = x;
                        cell_ys[cell_count] = y;
                        cell_count++;
                    end
                FUNC_QUERY:
                    if (q < cell_count)
                    begin
                        px   = cell_xs[q];
                        py   = cell_ys[q];
                        open = 4'b1111;
                        for (int j = 0; j < cell_count; j++)
                        begin
                            nx = cell_xs[j];
                            ny = cell_ys[j];
                            if (ny == py && nx == px + 1) open[0] = 1'b0;
                            if (ny == py && nx == px - 1) open[1] = 1'b0;
                            if (nx == px && ny == py + 1) open[2] = 1'b0;
                            if (nx == px && ny == py - 1) open[3] = 1'b0;
                        end
                        if (open[0])
                            push_wall(SIDE_PX, 2*px + 1, 2*py - 1, 2*px + 1, 2*py + 1,
                                      open[3:1] == 3'b000);
                        if (open[1])
                            push_wall(SIDE_MX, 2*px - 1, 2*py + 1, 2*px - 1, 2*py - 1,
                                      open[3:2] == 2'b00);
                        if (open[2])
                            push_wall(SIDE_PY, 2*px + 1, 2*py + 1, 2*px - 1, 2*py + 1,
                                      !open[3]);
                        if (open[3])
                            push_wall(SIDE_MY, 2*px - 1, 2*py - 1, 2*px + 1, 2*py - 1,
                                      1'b1);
                    end
                default:
                    ;
            endcase
        endfunction

        function void check_segment(wall_t got);
            wall_t want;
            if (walls_due.size() == 0)
                note_mismatch($sformatf("unexpected segment side %0d (%0d,%0d)-(%0d,%0d) last %0d",
                              got.side, got.sx, got.sy, got.ex, got.ey, got.last));
            else
            begin
                want = walls_due.pop_front();
                if (got.side !== want.side || got.sx !== want.sx || got.sy !== want.sy ||
                    got.ex !== want.ex || got.ey !== want.ey || got.last !== want.last)
                    note_mismatch($sformatf(
                        {"segment mismatch exp side %0d (%0d,%0d)-(%0d,%0d) last %0d",
                         " got side %0d (%0d,%0d)-(%0d,%0d) last %0d"},
                        want.side, want.sx, want.sy, want.ex, want.ey, want.last,
                        got.side, got.sx, got.sy, got.ex, got.ey, got.last));
            end
        endfunction
    endclass

    logic                      clk         = 1'b0;
    logic                      rst_n       = 1'b0;
    logic                      req_valid   = 1'b0;
    logic                      req_stall;
    logic [FUNC_W-1:0]         func        = FUNC_CLEAR;
    logic signed [COORD_W-1:0] cell_x      = '0;
    logic signed [COORD_W-1:0] cell_y      = '0;
    logic [QIDX_W-1:0]         query_index = '0;
    logic                      seg_valid;
    logic                      seg_stall   = 1'b0;
    logic [SIDE_W-1:0]         face_side;
    logic signed [SEG_W-1:0]   start_x;
    logic signed [SEG_W-1:0]   start_y;
    logic signed [SEG_W-1:0]   end_x;
    logic signed [SEG_W-1:0]   end_y;
    logic                      last_edge;

    wall_board   board;
    bit          hold_off_req = 1'b0;
    bit          calm         = 1'b0;
    int unsigned items_sent   = 0;

    grid_cell_boundary_edges_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .func        (func),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .query_index (query_index),
        .seg_valid   (seg_valid),
        .seg_stall   (seg_stall),
        .face_side   (face_side),
        .start_x     (start_x),
        .start_y     (start_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .last_edge   (last_edge)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * 2 * CLK_HALF);
        $display("simulation failed");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    task automatic send_req(input logic [FUNC_W-1:0] f, input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y, input logic [QIDX_W-1:0] q);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        func        <= f;
        cell_x      <= x;
        cell_y      <= y;
        query_index <= q;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        board.note_request(f, x, y, q);
        if (f != FUNC_UNUSED)
            items_sent++;
    endtask

    task automatic load_cell(input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y);
        send_req(FUNC_LOAD, x, y, QIDX_W'($urandom_range(0, 63)));
    endtask

    task automatic query_cell(input logic [QIDX_W-1:0] q);
        send_req(FUNC_QUERY, COORD_W'($urandom_range(0, 255)),
                 COORD_W'($urandom_range(0, 255)), q);
    endtask

    task automatic wait_all_segments();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (board.walls_due.size() != 0);
    endtask

    // output side: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                seg_stall    <= 1'b1;
                hold_off_req = 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                n = idle_len();
                seg_stall <= 1'b1;
                repeat (n + 1) @(posedge clk);
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 150) : idle_len() + 1;
                seg_stall <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin : seg_monitor
        wall_t got;
        if (rst_n && seg_valid && !seg_stall)
        begin
            got.side = face_side;
            got.sx   = start_x;
            got.sy   = start_y;
            got.ex   = end_x;
            got.ey   = end_y;
            got.last = last_edge;
            board.check_segment(got);
        end
    end

    initial
    begin
        int                        target;
        int                        phase;
        int                        kind;
        int                        nloads;
        int                        nq;
        int                        spread;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
        board = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        query_cell(0);
        load_cell(0, 0);
        load_cell(1, 0);
        load_cell(-1, 0);
        load_cell(0, 1);
        load_cell(0, -1);
        query_cell(0);
        query_cell(1);
        load_cell(127, -128);
        load_cell(-128, 127);
        load_cell(1, 0);
        query_cell(5);
        query_cell(6);
        query_cell(7);
        query_cell(63);
        send_req(FUNC_UNUSED, 8'sh55, -8'sh2B, 6'h2A);
        load_cell(127, 127);
        load_cell(-128, -128);
        load_cell(126, 127);
        query_cell(8);
        query_cell(9);
        query_cell(4);
        send_req(FUNC_CLEAR, -1, -1, 63);
        query_cell(0);
        load_cell(-1, -1);
        query_cell(0);
        wait_all_segments();

        // random phases: mostly clear, load a cluster, then query it
        target = items_sent + RANDOM_ITEMS;
        phase  = 0;
        while (items_sent < target)
        begin
            phase++;
            kind = $urandom_range(0, 19);
            calm = ($urandom_range(0, 4) == 0);
            if (kind != 0 || phase == 1)
                send_req(FUNC_CLEAR, COORD_W'($urandom_range(0, 255)),
                         COORD_W'($urandom_range(0, 255)), QIDX_W'($urandom_range(0, 63)));
            nloads = (kind == 19 || phase == 3) ? MAX_CELLS_DEF + $urandom_range(1, 3)
                                                : $urandom_range(1, 16);
            spread = $urandom_range(1, 4);
            bx     = COORD_W'($urandom_range(0, 255));
            by     = COORD_W'($urandom_range(0, 255));
            for (int i = 0; i < nloads; i++)
            begin
                load_cell(COORD_W'(bx + $urandom_range(0, spread)),
                          COORD_W'(by + $urandom_range(0, spread)));
                case ($urandom_range(0, 15))
                    0: send_req(FUNC_UNUSED, COORD_W'($urandom_range(0, 255)),
                                COORD_W'($urandom_range(0, 255)),
                                QIDX_W'($urandom_range(0, 63)));
                    1: query_cell(QIDX_W'($urandom_range(0, 63)));
                    default: ;
                endcase
            end
            if (phase == 2)
                hold_off_req = 1'b1;
            nq = $urandom_range(2, 8);
            for (int i = 0; i < nq; i++)
            begin
                if (board.cell_count == 0 || $urandom_range(0, 99) < 15)
                    query_cell(QIDX_W'($urandom_range(0, 63)));
                else
                    query_cell(QIDX_W'($urandom_range(0, board.cell_count - 1)));
            end
            if ($urandom_range(0, 5) == 0)
                wait_all_segments();
        end

        wait_all_segments();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.walls_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== grid_cell_boundary_edges_unit.f =====
+incdir+hw/rtl
hw/rtl/gcbe_pkg.sv
hw/rtl/gcbe_ram.sv
hw/rtl/gcbe_nbr.sv
hw/rtl/grid_cell_boundary_edges_unit.sv
tb/tb_grid_cell_boundary_edges_unit.sv
